// ----- rtl/core/scfr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfr_pkg: shared types and constants for the sentence CRC trailer framer
// Queue entry type, CRC-16 byte step, trailer character codes.
// ----------------------------------------------------------------------------
package scfr_pkg;

    // CRC-16, polynomial 0x1021, MSB first, init 0xFFFF
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // bytes of lead-in that are not fed to the CRC
    localparam logic [1:0] LEAD_IN_BYTES = 2'd2;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // trailer characters
    localparam logic [7:0] CHAR_STAR = 8'h2A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_A    = 8'h41;

    // emit step within one queue entry
    typedef enum logic [2:0] {
        STEP_BYTE  = 3'd0,
        STEP_STAR  = 3'd1,
        STEP_HEX3  = 3'd2,
        STEP_HEX2  = 3'd3,
        STEP_HEX1  = 3'd4,
        STEP_HEX0  = 3'd5,
        STEP_CR    = 3'd6,
        STEP_LF    = 3'd7
    } step_t;

    // one classified sentence byte
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last;
        logic [15:0] crc;
    } entry_t;

    // one byte of the CRC-16 update (poly 0x1021, MSB first), eight bit steps
    function automatic logic [15:0] crc_byte_step(input logic [15:0] crc,
                                                  input logic [7:0]  b);
        logic [15:0] r;
        r = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (r[15])
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            else
                r = {r[14:0], 1'b0};
        end
        return r;
    endfunction

    // upper-case ASCII hex digit
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        if (nib < 4'd10)
            d = CHAR_ZERO + {4'd0, nib};
        else
            d = CHAR_A + {4'd0, nib - 4'd10};
        return d;
    endfunction

endpackage

// ----- rtl/core/scfr_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfr_in_if: sentence byte input channel
// valid/ready handshake carrying one sentence character and its end flag.
// ----------------------------------------------------------------------------
interface scfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_sentence;

    modport source (output valid, output data_byte, output end_of_sentence,
                    input ready);
    modport sink   (input valid, input data_byte, input end_of_sentence,
                    output ready);
endinterface

// ----- rtl/core/scfr_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfr_out_if: framed byte output channel
// valid/ready handshake carrying one output character and its frame end flag.
// ----------------------------------------------------------------------------
interface scfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last,
                    output ready);
endinterface

// ----- rtl/core/sentence_crc_trailer_framer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sentence_crc_trailer_framer: telemetry sentence CRC trailer framer
// Passes sentence bytes through and appends "*XXXX\r\n" with the CRC-16.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                         | handshake
//  ---------+-----+---------------------------------+------------
//  in_ch    | in  | data_byte[7:0], end_of_sentence | valid/ready
//  out_ch   | out | out_byte[7:0], out_last         | valid/ready
//
//  One input byte per cycle unless the queue is full, one output byte per
//  cycle while out_ready is high; a flagged last byte occupies the output for
//  the byte plus seven trailer bytes. The CRC byte step is one combinational
//  stage in the front; bytes pass the queue, then the output register. The
//  two-entry queue takes one more byte while the trailer drains, then the
//  input stalls until the line feed is loaded. Reset clears CRC to 0xFFFF,
//  lead-in count, queue and output register; no item is lost under stalls.
// ----------------------------------------------------------------------------
module sentence_crc_trailer_framer (
    input  logic          clk,
    input  logic          rst_n,
    scfr_in_if.sink       in_ch,
    scfr_out_if.source    out_ch
);

    logic              push, pop, full, not_empty;
    scfr_pkg::entry_t  push_entry, head;

    scfr_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_ch.valid),
        .in_ready        (in_ch.ready),
        .data_byte       (in_ch.data_byte),
        .end_of_sentence (in_ch.end_of_sentence),
        .queue_full      (full),
        .push            (push),
        .push_entry      (push_entry)
    );

    scfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .not_empty  (not_empty),
        .head       (head)
    );

    scfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_byte  (out_ch.out_byte),
        .out_last  (out_ch.out_last)
    );

endmodule

// ----- rtl/core/scfr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfr_front: input side of the framer
// Counts the lead-in, runs the CRC and hands classified bytes to the queue.
// ----------------------------------------------------------------------------
module scfr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                end_of_sentence,
    input  logic                queue_full,
    output logic                push,
    output scfr_pkg::entry_t    push_entry
);

    logic [1:0]  position_count_reg, position_count_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] crc_upd;
    logic        in_lead;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;
    assign in_lead  = position_count_reg < scfr_pkg::LEAD_IN_BYTES;

    // CRC after this byte, lead-in bytes leave it alone
    always_comb
    begin
        if (in_lead)
            crc_upd = crc_reg;
        else
            crc_upd = scfr_pkg::crc_byte_step(crc_reg, data_byte);
    end

    assign push_entry.data_byte = data_byte;
    assign push_entry.last      = end_of_sentence;
    assign push_entry.crc       = crc_upd;

    // sentence state update per transfer
    always_comb
    begin
        position_count_next = position_count_reg;
        crc_next            = crc_reg;
        if (push)
        begin
            if (end_of_sentence)
            begin
                position_count_next = 2'd0;
                crc_next            = scfr_pkg::CRC_INIT;
            end
            else
            begin
                crc_next = crc_upd;
                if (in_lead)
                    position_count_next = position_count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_count_reg <= 2'd0;
            crc_reg            <= scfr_pkg::CRC_INIT;
        end
        else
        begin
            position_count_reg <= position_count_next;
            crc_reg            <= crc_next;
        end
    end

endmodule

// ----- rtl/core/scfr_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfr_queue: short queue between front and back
// Two-entry FIFO of classified bytes; head is visible combinationally.
// ----------------------------------------------------------------------------
module scfr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  scfr_pkg::entry_t    push_entry,
    input  logic                pop,
    output logic                full,
    output logic                not_empty,
    output scfr_pkg::entry_t    head
);

    scfr_pkg::entry_t                   mem_reg [scfr_pkg::QUEUE_DEPTH];
    logic [scfr_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [scfr_pkg::QUEUE_CNT_W-1:0]   count_reg;

    assign full      = count_reg == scfr_pkg::QUEUE_CNT_W'(scfr_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + scfr_pkg::QUEUE_CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - scfr_pkg::QUEUE_CNT_W'(1);
        end
    end

endmodule

// ----- rtl/core/scfr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfr_back: output side of the framer
// Emits each queued byte and, after a last byte, the "*XXXX\r\n" trailer.
// ----------------------------------------------------------------------------
module scfr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                not_empty,
    input  scfr_pkg::entry_t    head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                out_last
);

    scfr_pkg::step_t step_reg, step_next;
    logic            out_valid_reg;
    logic [7:0]      out_byte_reg;
    logic            out_last_reg;
    logic            load;
    logic [7:0]      char_sel;
    logic            last_sel;
    logic            entry_done;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    // output register free or being drained this cycle
    assign load = not_empty && (!out_valid_reg || out_ready);

    // character for the current step
    always_comb
    begin
        last_sel = 1'b0;
        case (step_reg)
            scfr_pkg::STEP_BYTE: char_sel = head.data_byte;
            scfr_pkg::STEP_STAR: char_sel = scfr_pkg::CHAR_STAR;
            scfr_pkg::STEP_HEX3: char_sel = scfr_pkg::hex_digit(head.crc[15:12]);
            scfr_pkg::STEP_HEX2: char_sel = scfr_pkg::hex_digit(head.crc[11:8]);
            scfr_pkg::STEP_HEX1: char_sel = scfr_pkg::hex_digit(head.crc[7:4]);
            scfr_pkg::STEP_HEX0: char_sel = scfr_pkg::hex_digit(head.crc[3:0]);
            scfr_pkg::STEP_CR:   char_sel = scfr_pkg::CHAR_CR;
            scfr_pkg::STEP_LF:
            begin
                char_sel = scfr_pkg::CHAR_LF;
                last_sel = 1'b1;
            end
            default:             char_sel = head.data_byte;
        endcase
    end

    // entry finished after its byte, or after the line feed of its trailer
    assign entry_done = (step_reg == scfr_pkg::STEP_BYTE && !head.last) ||
                        (step_reg == scfr_pkg::STEP_LF);
    assign pop        = load && entry_done;

    always_comb
    begin
        step_next = step_reg;
        if (load)
        begin
            if (entry_done)
                step_next = scfr_pkg::STEP_BYTE;
            else
                step_next = scfr_pkg::step_t'(step_reg + 3'd1);
        end
    end

    // step counter and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= scfr_pkg::STEP_BYTE;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= 8'd0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
                out_byte_reg  <= char_sel;
                out_last_reg  <= last_sel;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- tb/scfr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfr_checker: output checker for the sentence CRC trailer framer
// Watches both channels. Each byte taken in is run through a local CRC-16
// and framing model, and the characters it should produce are queued. Each
// character sent out is compared with the oldest queued one.
// ----------------------------------------------------------------------------
module scfr_checker (
    input  logic clk,
    input  logic rst_n,
    scfr_in_if   in_ch,
    scfr_out_if  out_ch,
    output int   errors,
    output int   pending
);

    localparam logic [15:0] CCITT_POLY = 16'h1021;
    localparam logic [15:0] CCITT_SEED = 16'hFFFF;
    localparam logic [1:0]  LEAD_IN    = 2'd2;
    localparam logic [7:0]  ASCII_STAR = 8'h2A;
    localparam logic [7:0]  ASCII_CR   = 8'h0D;
    localparam logic [7:0]  ASCII_LF   = 8'h0A;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } framed_char_t;

    framed_char_t expected_chars[$];
    logic [15:0]  sentence_crc = CCITT_SEED;
    logic [1:0]   lead_count   = 2'd0;

    // one byte into the CRC, one message bit at a time
    function automatic logic [15:0] ccitt_update(input logic [15:0] crc,
                                                 input logic [7:0]  b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb)
                c = c ^ CCITT_POLY;
        end
        return c;
    endfunction

    function automatic logic [7:0] nibble_ascii(input logic [3:0] n);
        if (n > 4'd9)
            return 8'd55 + {4'd0, n};   // 'A' - 10
        return 8'd48 + {4'd0, n};       // '0'
    endfunction

    // queue the characters one input byte produces
    function automatic void frame_byte(input logic [7:0] b, input logic eos);
        if (lead_count < LEAD_IN)
            lead_count = lead_count + 2'd1;
        else
            sentence_crc = ccitt_update(sentence_crc, b);
        expected_chars.push_back('{ch: b, fin: 1'b0});
        if (eos)
        begin
            expected_chars.push_back('{ch: ASCII_STAR, fin: 1'b0});
            expected_chars.push_back('{ch: nibble_ascii(sentence_crc[15:12]), fin: 1'b0});
            expected_chars.push_back('{ch: nibble_ascii(sentence_crc[11:8]), fin: 1'b0});
            expected_chars.push_back('{ch: nibble_ascii(sentence_crc[7:4]), fin: 1'b0});
            expected_chars.push_back('{ch: nibble_ascii(sentence_crc[3:0]), fin: 1'b0});
            expected_chars.push_back('{ch: ASCII_CR, fin: 1'b0});
            expected_chars.push_back('{ch: ASCII_LF, fin: 1'b1});
            sentence_crc = CCITT_SEED;
            lead_count   = 2'd0;
        end
    endfunction

    task automatic log_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        errors++;
    endtask

    // sample both channels on the rising edge
    always @(posedge clk)
    begin
        framed_char_t want;
        if (!rst_n)
        begin
            sentence_crc = CCITT_SEED;
            lead_count   = 2'd0;
            expected_chars.delete();
        end
        else
        begin
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                frame_byte(in_ch.data_byte, in_ch.end_of_sentence);

            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                if (expected_chars.size() == 0)
                    log_mismatch($sformatf("unexpected output transfer byte=%h last=%b",
                                           out_ch.out_byte, out_ch.out_last));
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_ch.out_byte !== want.ch)
                        log_mismatch($sformatf("out_byte %h, want %h",
                                               out_ch.out_byte, want.ch));
                    if (out_ch.out_last !== want.fin)
                        log_mismatch($sformatf("out_last %b, want %b (byte %h)",
                                               out_ch.out_last, want.fin, want.ch));
                end
            end
        end
        pending = expected_chars.size();
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the sentence CRC trailer framer
// Sends directed sentences (short ones, zero and all-ones bytes, a known
// CRC check string) and then random sentences, with random gaps on both
// channels, a long output stall and a full drain mid-run. Checking is done
// by scfr_checker.
// ----------------------------------------------------------------------------
module tb;

    logic clk;
    logic rst_n;
    int   err_count;
    int   outstanding;
    bit   no_gaps;
    int   hold_requests;
    int   items_sent;

    scfr_in_if  in_ch ();
    scfr_out_if out_ch ();

    sentence_crc_trailer_framer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    scfr_checker i_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .errors  (err_count),
        .pending (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #500000;
        $display("Verification failed");
        $finish;
    end

    // output side: random back-pressure, long hold-off on request
    initial
    begin
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = 80;
            end
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (no_gaps)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(0, 99) >= 17);
        end
    end

    // one input transfer; valid stays up for a back-to-back follower
    task automatic send_byte(input logic [7:0] b, input logic eos);
        @(negedge clk);
        while (!no_gaps && $urandom_range(0, 99) < 17)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.data_byte       <= b;
        in_ch.end_of_sentence <= eos;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        items_sent++;
    endtask

    // drop valid and wait until every queued character has come out
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // mostly "$$"-led sentences with printable text; some short ones and noise
    task automatic send_random_sentence();
        int         len;
        int         kind;
        logic [7:0] b;
        kind = $urandom_range(0, 9);
        if (kind == 0)
            len = $urandom_range(1, 2);
        else
            len = $urandom_range(3, 20);
        for (int i = 0; i < len; i++)
        begin
            if (kind != 9 && i < 2)
                b = "$";
            else if (kind == 9 || $urandom_range(0, 3) == 0)
                b = $urandom_range(0, 255);
            else
                b = $urandom_range(32, 126);
            send_byte(b, i == len - 1);
        end
    endtask

    initial
    begin
        string check_str;
        bit    done_hold;
        bit    done_quiet;
        bit    done_pause;
        done_hold             = 1'b0;
        done_quiet            = 1'b0;
        done_pause            = 1'b0;
        no_gaps               = 1'b0;
        hold_requests         = 0;
        items_sent            = 0;
        rst_n                 = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.data_byte       = 8'h00;
        in_ch.end_of_sentence = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // minimal sentence: last byte is the first one fed to the CRC
        send_byte(8'h24, 1'b0);
        send_byte(8'h24, 1'b0);
        send_byte(8'h7F, 1'b1);
        // one- and two-byte sentences leave the CRC at its seed
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b1);
        // zero byte past the lead-in
        send_byte(8'h24, 1'b0);
        send_byte(8'h24, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // standard check string, CRC 29B1
        check_str = "$$123456789";
        for (int i = 0; i < check_str.len(); i++)
            send_byte(check_str[i], i == check_str.len() - 1);
        drain();

        while (items_sent < 250)
        begin
            if (!done_hold && items_sent >= 80)
            begin
                done_hold = 1'b1;
                hold_requests++;
            end
            if (!done_quiet && items_sent >= 140)
            begin
                done_quiet = 1'b1;
                no_gaps    = 1'b1;
            end
            if (no_gaps && items_sent >= 190)
                no_gaps = 1'b0;
            if (!done_pause && items_sent >= 220)
            begin
                done_pause = 1'b1;
                drain();
            end
            send_random_sentence();
        end
        drain();
        repeat (12) @(negedge clk);

        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
